// ===== hw/rtl/rnt_pkg.sv =====
// constants and the digit lookup for the radix number to text unit
// no dependencies; imported by radix_number_to_text_unit and its testbench
package rnt_pkg;

    localparam int EXT_BITS = 64;
    localparam int CHAR_BITS = 7;
    localparam int DIGIT_BITS = 4;
    localparam int BASE_BITS = 5;
    localparam int FLAG_BITS = 2;

    localparam logic [BASE_BITS-1:0] BASE_MIN = 5'd2;
    localparam logic [BASE_BITS-1:0] BASE_MAX = 5'd16;

    localparam logic [CHAR_BITS-1:0] MINUS_CHAR = 7'h2d;
    localparam logic [CHAR_BITS-1:0] ZERO_CHAR = 7'h30;
    localparam logic [CHAR_BITS-1:0] LOWER_A_CHAR = 7'h61;
    localparam logic [CHAR_BITS-1:0] UPPER_A_CHAR = 7'h41;

    localparam int FLAG_UNSIGNED = 0;
    localparam int FLAG_LOWER = 1;

    typedef logic [DIGIT_BITS-1:0] digit_t;
    typedef logic [CHAR_BITS-1:0] char_t;

    function automatic char_t digit_char(input digit_t d, input logic lower);
        char_t c;
        if (d < 4'd10)
        begin
            c = ZERO_CHAR + CHAR_BITS'(d);
        end
        else if (lower)
        begin
            c = LOWER_A_CHAR + CHAR_BITS'(d - 4'd10);
        end
        else
        begin
            c = UPPER_A_CHAR + CHAR_BITS'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/radix_number_to_text_unit.sv =====
// radix number to text unit: integer to ascii digits in base 2..16
// depends on rnt_pkg (constants, digit lookup)
//
// usage
//   slave word: s_tdata holds value and base, s_tuser holds the flags
//   (bit0 unsigned, bit1 lowercase letters). a word is taken when s_tvalid
//   and s_tready are both high; s_tready is high only while the unit is idle
//   master words: one ascii character each on m_tdata, most significant
//   first, with a leading '-' for a negative signed value; m_tlast marks the
//   final character of the number
//   each digit comes from a restoring division by the base, one quotient bit
//   per cycle over all VALUE_BITS bits of the quotient; base 2 gives the most
//   digits, up to VALUE_BITS; the '-' is loaded on the last divider cycle,
//   and each digit character goes through the digit memory read port and
//   then the output register
//   the output register holds its word unchanged while m_tready is low
//   reset empties the output register and returns the unit to idle; the
//   digit memory is not cleared, every entry is written before it is read
module radix_number_to_text_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], base [36:32], zero [39:37]
    input  logic [rnt_pkg::FLAG_BITS-1:0] s_tuser,  // flags [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character [6:0], zero [7]
    output logic        m_tlast
);
    import rnt_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int IW = $clog2(VALUE_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [DIGIT_BITS-1:0] rem_reg, rem_next;
    logic                  nz_reg, nz_next;
    logic [IW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [BASE_BITS-1:0]  base_reg, base_next;
    logic                  lower_reg, lower_next;
    logic                  neg_reg, neg_next;
    char_t                 char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  valid_reg, valid_next;
    digit_t                rd_data_reg;

    digit_t                digit_mem [VALUE_BITS];

    logic [EXT_BITS-1:0]   value_ext;
    logic [VALUE_BITS-1:0] raw;
    logic                  raw_neg;
    logic [BASE_BITS-1:0]  base_in;
    logic [BASE_BITS-1:0]  rem_shift;
    logic [BASE_BITS-1:0]  rem_sub;
    logic                  ge;
    digit_t                rem_step;
    logic                  nz_step;
    logic                  mem_we;
    logic                  mem_re;
    logic                  in_fire;
    logic                  out_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = valid_reg && m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

    assign value_ext = {{(EXT_BITS - 32){s_tdata[31]}}, s_tdata[31:0]};
    assign raw       = value_ext[VALUE_BITS-1:0];
    assign raw_neg   = !s_tuser[FLAG_UNSIGNED] && raw[VALUE_BITS-1];

    always_comb
    begin
        if (s_tdata[36:32] < BASE_MIN)
        begin
            base_in = BASE_MIN;
        end
        else if (s_tdata[36:32] > BASE_MAX)
        begin
            base_in = BASE_MAX;
        end
        else
        begin
            base_in = s_tdata[36:32];
        end
    end

    // one restoring division step
    assign rem_shift = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign ge        = (rem_shift >= base_reg);
    assign rem_sub   = rem_shift - base_reg;
    assign rem_step  = ge ? rem_sub[DIGIT_BITS-1:0] : rem_shift[DIGIT_BITS-1:0];
    assign nz_step   = nz_reg | ge;

    always_comb
    begin
        state_next   = state_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        nz_next      = nz_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        base_next    = base_reg;
        lower_next   = lower_reg;
        neg_next     = neg_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        valid_next   = valid_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    quot_next    = raw_neg ? (VALUE_BITS'(0) - raw) : raw;
                    rem_next     = '0;
                    nz_next      = 1'b0;
                    bit_cnt_next = IW'(VALUE_BITS - 1);
                    count_next   = '0;
                    base_next    = base_in;
                    lower_next   = s_tuser[FLAG_LOWER];
                    neg_next     = raw_neg;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quot_next = {quot_reg[VALUE_BITS-2:0], ge};
                rem_next  = rem_step;
                nz_next   = nz_step;
                if (bit_cnt_reg == '0)
                begin
                    mem_we       = 1'b1;
                    count_next   = count_reg + 1'b1;
                    rem_next     = '0;
                    nz_next      = 1'b0;
                    bit_cnt_next = IW'(VALUE_BITS - 1);
                    if (!(nz_step && (count_reg < CW'(VALUE_BITS - 1))))
                    begin
                        if (neg_reg)
                        begin
                            char_next  = MINUS_CHAR;
                            last_next  = 1'b0;
                            valid_next = 1'b1;
                            state_next = ST_WAIT;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                count_next = count_reg - 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                char_next  = digit_char(rd_data_reg, lower_reg);
                last_next  = (count_reg == '0);
                valid_next = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_fire)
                begin
                    valid_next = 1'b0;
                    state_next = last_reg ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= 1'b0;
            count_reg   <= '0;
            bit_cnt_reg <= '0;
            quot_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            bit_cnt_reg <= bit_cnt_next;
            quot_reg    <= quot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        nz_reg    <= nz_next;
        base_reg  <= base_next;
        lower_reg <= lower_next;
        neg_reg   <= neg_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    // digit memory, write during division, registered read during output
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[count_reg[IW-1:0]] <= rem_step;
        end
    end

    logic [CW-1:0] rd_count;
    assign rd_count = count_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= digit_mem[rd_count[IW-1:0]];
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input accepted while a word is pending");

    a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (count_reg == '0))
        else $error("last character with digits left");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (count_reg < CW'(VALUE_BITS)))
        else $error("digit count beyond memory depth");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("unit not idle after final character");

    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[6:0] == MINUS_CHAR)) |-> !m_tlast)
        else $error("minus sign marked as last");

endmodule

// ===== sim/tb_radix_number_to_text_unit.sv =====
// testbench for radix_number_to_text_unit: numbers in, ascii digit words out
// depends on rnt_pkg and radix_number_to_text_unit; checks every character and last mark
// against its own conversion of each accepted number, with random stalls on both sides
module tb_radix_number_to_text_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import rnt_pkg::*;

    localparam int NUM_BITS = 32;
    localparam int HALF_PERIOD = 4;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int TAIL_CYCLES = 200;
    localparam int CALM_TAIL = 40;
    localparam int RANDOM_NUMBERS = 290;

    localparam logic [0:15][7:0] LOWER_DIGITS = "0123456789abcdef";
    localparam logic [0:15][7:0] UPPER_DIGITS = "0123456789ABCDEF";

    typedef struct {
        logic [NUM_BITS-1:0]  value;
        logic [BASE_BITS-1:0] base;
        logic [FLAG_BITS-1:0] flags;
    } number_word_t;

    typedef struct {
        char_t ch;
        logic  last;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [39:0] s_tdata = '0;
    logic [FLAG_BITS-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic m_tlast;

    number_word_t numbers_pending [$];
    text_char_t text_due [$];
    int send_hold = 0;
    int recv_hold = 0;
    int quiet_cycles = 0;
    int mismatches = 0;

    radix_number_to_text_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    // idling in the middle of the run, with calm stretches and a calm tail
    function automatic logic idling_allowed();
        return (numbers_pending.size() > CALM_TAIL) && ((numbers_pending.size() % 64) >= 16);
    endfunction

    function automatic void add_number(input logic [NUM_BITS-1:0] value,
                                       input logic [BASE_BITS-1:0] base,
                                       input logic [FLAG_BITS-1:0] flags);
        number_word_t w;
        w.value = value;
        w.base = base;
        w.flags = flags;
        numbers_pending.push_back(w);
    endfunction

    // text of one number: optional minus, then the digits most significant first
    function automatic void convert_to_text(input number_word_t w);
        logic [BASE_BITS-1:0] radix;
        logic [NUM_BITS-1:0] magnitude;
        logic negative;
        logic [3:0] digits [$];
        text_char_t c;
        radix = w.base;
        if (radix < BASE_MIN)
        begin
            radix = BASE_MIN;
        end
        if (radix > BASE_MAX)
        begin
            radix = BASE_MAX;
        end
        negative = !w.flags[FLAG_UNSIGNED] && w.value[NUM_BITS-1];
        magnitude = negative ? (~w.value + 1'b1) : w.value;
        do
        begin
            digits.push_back(4'(magnitude % NUM_BITS'(radix)));
            magnitude = magnitude / NUM_BITS'(radix);
        end
        while (magnitude != 0);
        if (negative)
        begin
            c.ch = MINUS_CHAR;
            c.last = 1'b0;
            text_due.push_back(c);
        end
        while (digits.size() > 0)
        begin
            if (w.flags[FLAG_LOWER])
            begin
                c.ch = char_t'(LOWER_DIGITS[digits[$]]);
            end
            else
            begin
                c.ch = char_t'(UPPER_DIGITS[digits[$]]);
            end
            void'(digits.pop_back());
            c.last = (digits.size() == 0);
            text_due.push_back(c);
        end
    endfunction

    // driver: feeds numbers from the pending queue
    always @(posedge clk or negedge rst_n)
    begin : number_driver
        number_word_t w;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            send_hold <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                w.value = s_tdata[31:0];
                w.base = s_tdata[36:32];
                w.flags = s_tuser;
                convert_to_text(w);
            end
            if (send_hold > 0)
            begin
                send_hold <= send_hold - 1;
                s_tvalid <= 1'b0;
            end
            else if (idling_allowed() && $urandom_range(0, 3) == 0)
            begin
                send_hold <= $urandom_range(0, 10);
                s_tvalid <= 1'b0;
            end
            else if (numbers_pending.size() > 0)
            begin
                w = numbers_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {3'b000, w.base, w.value};
                s_tuser <= w.flags;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each character word against the oldest expected one
    always @(posedge clk or negedge rst_n)
    begin : text_monitor
        text_char_t due;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_hold <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (text_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got %h last %b",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    due = text_due.pop_front();
                    if (m_tdata !== {1'b0, due.ch})
                    begin
                        $display("%0t: character expected %h, got %h",
                                 $time, {1'b0, due.ch}, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== due.last)
                    begin
                        $display("%0t: last expected %b, got %b", $time, due.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold <= recv_hold - 1;
                m_tready <= 1'b0;
            end
            else if (idling_allowed() && $urandom_range(0, 5) == 0)
            begin
                recv_hold <= $urandom_range(0, 10);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("radix_number_to_text_unit: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int i;
        int kind;
        logic [NUM_BITS-1:0] v;
        logic [BASE_BITS-1:0] b;

        // zero, extremes, most negative, clamped bases, every flag setting
        add_number(32'h0000_0000, 5'd10, 2'b00);
        add_number(32'h0000_0000, 5'd2, 2'b01);
        add_number(32'h7fff_ffff, 5'd10, 2'b00);
        add_number(32'h8000_0000, 5'd10, 2'b00);
        add_number(32'h8000_0000, 5'd2, 2'b10);
        add_number(32'h8000_0000, 5'd16, 2'b01);
        add_number(32'hffff_ffff, 5'd2, 2'b01);
        add_number(32'hffff_ffff, 5'd10, 2'b00);
        add_number(32'hffff_ffff, 5'd16, 2'b11);
        add_number(32'hffff_ffff, 5'd16, 2'b01);
        add_number(32'h0000_00ff, 5'd16, 2'b10);
        add_number(32'h0000_00ff, 5'd16, 2'b00);
        add_number(32'hdead_beef, 5'd16, 2'b11);
        add_number(32'h1234_5678, 5'd0, 2'b00);
        add_number(32'h1234_5678, 5'd1, 2'b01);
        add_number(32'hfedc_ba98, 5'd17, 2'b10);
        add_number(32'hfedc_ba98, 5'd31, 2'b11);
        add_number(32'd12345, 5'd7, 2'b00);
        add_number(-32'sd12345, 5'd8, 2'b10);
        add_number(32'd15, 5'd16, 2'b00);
        add_number(32'd1, 5'd3, 2'b00);
        add_number(32'd35, 5'd15, 2'b10);

        for (i = 0; i < RANDOM_NUMBERS; i++)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: v = $urandom;
                4, 5: v = $urandom_range(0, 2000);
                6: v = -$urandom_range(1, 2000);
                7: v = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                            : 32'h8000_0000 + $urandom_range(0, 3);
                default: v = $urandom >> $urandom_range(0, 31);
            endcase
            b = ($urandom_range(0, 9) == 0) ? BASE_BITS'($urandom_range(0, 31))
                                            : BASE_BITS'($urandom_range(2, 16));
            add_number(v, b, FLAG_BITS'($urandom_range(0, 3)));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (numbers_pending.size() != 0 || s_tvalid || text_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && text_due.size() == 0)
        begin
            $display("radix_number_to_text_unit: match");
        end
        else
        begin
            $display("radix_number_to_text_unit: mismatch");
        end
        $finish;
    end

endmodule
